// ===== rtl/rwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared types, codes and sizes of the reader/writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // field widths
  localparam int unsigned KEY_W = 64;
  localparam int unsigned RD_W  = 8;

  // saturation point of the shared count
  localparam logic [RD_W-1:0] MAX_READERS = 8'd255;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_KEY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KEY = 1'd1;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SB     = 2'd2,
    OP_UNLOCK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_WRITE_LOCKED = 3'd2,
    ST_ALREADY      = 3'd3,
    ST_SB_HELD      = 3'd4,
    ST_NOT_LOCKED   = 3'd5,
    ST_FULL         = 3'd6,
    ST_OVERFLOW     = 3'd7
  } status_e;

  // request payload
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
  } req_t;

  // result payload
  typedef struct packed {
    status_e         status;
    logic [RD_W-1:0] readers;
    logic            write_held;
    logic            superblock_held;
  } rsp_t;

  // classified request held in the queue
  typedef struct packed {
    req_t req;
    logic in_range;
  } cls_t;

  // queue occupancy
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

endpackage

// ===== rtl/reader_writer_lock_table_top.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_table_top
// Reader/writer lock table on 64-bit block keys with a superblock lock.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : request (op, key) with in_valid_i / in_ready_o.
//   out channel : one result per request (status, readers, write_held,
//                 superblock_held) with out_valid_o / out_ready_i, in order.
//   cfg channel : cfg_index_i selects low_key (0) or high_key (1); writes
//                 are always taken and must only happen while the block idles.
// Order: an accepted request is written into the request queue, then carried
//   out by the back end, whose result register drives out_valid_o.
// Throughput: one request per cycle while no result is held; the 16 table
//   entries are matched in parallel and updated by the back end once per request.
// Reset: all entries and the superblock are freed at once, the key range
//   opens to the full 64-bit space.
// Stall: a held result stops the back end; the two-entry request queue
//   keeps taking requests until it fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module reader_writer_lock_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rwlt_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rwlt_pkg::rsp_t                 out_rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rwlt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rwlt_pkg::KEY_W-1:0]     cfg_data_i
);
  import rwlt_pkg::*;

  logic    push_valid, push_ready;
  cls_t    push_data;
  logic    pop_valid, pop_ready;
  cls_t    pop_data;
  q_stat_t q_stat;

  // request classification
  rwlt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoupling queue
  rwlt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .stat_o       (q_stat)
  );

  // lock table
  rwlt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // no request taken into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !q_stat.full)
    else $error("request accepted while queue full");

  // queue count follows push and pop
  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready && !(pop_valid && pop_ready)) |=>
      (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count lost a push");

  // write locked result reports a write holder with no readers
  a_wl_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_WRITE_LOCKED)) |->
      (out_rsp_o.write_held && (out_rsp_o.readers == '0)))
    else $error("write locked result with inconsistent view");

  // superblock held result implies a superblock
  a_sb_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_SB_HELD)) |-> out_rsp_o.superblock_held)
    else $error("superblock held result without superblock");

  // readers and write holder exclude each other
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.write_held) |-> (out_rsp_o.readers == '0))
    else $error("key reported both read and write locked");

endmodule

// ===== rtl/rwlt_front.sv =====
// ----------------------------------------------------------------------------
// rwlt_front
// Holds the key range registers and tags each request with its range check.
// ----------------------------------------------------------------------------
module rwlt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rwlt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rwlt_pkg::KEY_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rwlt_pkg::req_t                in_req_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output rwlt_pkg::cls_t                push_data_o
);
  import rwlt_pkg::*;

  logic [KEY_W-1:0] low_key_q, low_key_d;
  logic [KEY_W-1:0] high_key_q, high_key_d;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    low_key_d  = low_key_q;
    high_key_d = high_key_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_KEY:  low_key_d  = cfg_data_i;
        CFG_HIGH_KEY: high_key_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_key_q  <= '0;
      high_key_q <= '1;
    end else begin
      low_key_q  <= low_key_d;
      high_key_q <= high_key_d;
    end
  end

  // range check and hand-off to the queue
  assign push_valid_o         = in_valid_i;
  assign in_ready_o           = push_ready_i;
  assign push_data_o.req      = in_req_i;
  assign push_data_o.in_range = (in_req_i.key >= low_key_q) && (in_req_i.key <= high_key_q);

endmodule

// ===== rtl/rwlt_queue.sv =====
// ----------------------------------------------------------------------------
// rwlt_queue
// Short FIFO of classified requests between the front and the lock table.
// ----------------------------------------------------------------------------
module rwlt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rwlt_pkg::cls_t    push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rwlt_pkg::cls_t    pop_data_o,
  output rwlt_pkg::q_stat_t stat_o
);
  import rwlt_pkg::*;

  cls_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  assign stat_o.count = count_q;
  assign stat_o.full  = !push_ready_o;
  assign stat_o.empty = !pop_valid_o;

  // pointer and count update with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/rwlt_back.sv =====
// ----------------------------------------------------------------------------
// rwlt_back
// Lock table: parallel key match, one update per request, result register.
// ----------------------------------------------------------------------------
module rwlt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  rwlt_pkg::cls_t pop_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rwlt_pkg::rsp_t out_rsp_o
);
  import rwlt_pkg::*;

  // table entries
  logic             valid_q [TABLE_ENTRIES];
  logic [KEY_W-1:0] key_q   [TABLE_ENTRIES];
  logic             write_q [TABLE_ENTRIES];
  logic [RD_W-1:0]  rd_q    [TABLE_ENTRIES];
  logic             sb_valid_q, sb_valid_d;
  logic [KEY_W-1:0] sb_key_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;

  logic             fire;
  logic             hit, free_ok;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic             hit_write;
  logic [RD_W-1:0]  hit_rd;
  status_e          status;
  logic             do_alloc, alloc_write, do_inc, do_dec, do_free, sb_set;
  logic [RD_W-1:0]  view_rd;
  logic             view_write;

  assign fire        = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !out_valid_q || out_ready_i;

  // key match and lowest free entry
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (valid_q[i] && (key_q[i] == pop_data_i.req.key)) begin
        hit     = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_write = write_q[hit_idx];
  assign hit_rd    = rd_q[hit_idx];

  // operation decode and result view
  always_comb begin
    status      = ST_OK;
    do_alloc    = 1'b0;
    alloc_write = 1'b0;
    do_inc      = 1'b0;
    do_dec      = 1'b0;
    do_free     = 1'b0;
    sb_set      = 1'b0;
    sb_valid_d  = sb_valid_q;
    // current view of the key, kept when the request fails
    view_write  = hit && hit_write;
    view_rd     = (hit && !hit_write) ? hit_rd : '0;
    case (pop_data_i.req.op)
      OP_READ: begin
        if (!pop_data_i.in_range) begin
          status = ST_INVALID;
        end else if (hit) begin
          if (hit_write) begin
            status = ST_WRITE_LOCKED;
          end else if (hit_rd >= MAX_READERS) begin
            status = ST_OVERFLOW;
          end else begin
            do_inc  = 1'b1;
            view_rd = hit_rd + 1'b1;
          end
        end else if (!free_ok) begin
          status = ST_FULL;
        end else begin
          do_alloc = 1'b1;
          view_rd  = RD_W'(1);
        end
      end
      OP_WRITE, OP_SB: begin
        if ((pop_data_i.req.op == OP_SB) && sb_valid_q) begin
          status = ST_SB_HELD;
        end else if (!pop_data_i.in_range) begin
          status = ST_INVALID;
        end else if (hit) begin
          status = ST_ALREADY;
        end else if (!free_ok) begin
          status = ST_FULL;
        end else begin
          do_alloc    = 1'b1;
          alloc_write = 1'b1;
          view_write  = 1'b1;
          view_rd     = '0;
          if (pop_data_i.req.op == OP_SB) begin
            sb_set     = 1'b1;
            sb_valid_d = 1'b1;
          end
        end
      end
      OP_UNLOCK: begin
        if (!pop_data_i.in_range) begin
          status = ST_INVALID;
        end else if (!hit) begin
          status = ST_NOT_LOCKED;
        end else begin
          if (!hit_write && (hit_rd > RD_W'(1))) begin
            do_dec  = 1'b1;
            view_rd = hit_rd - 1'b1;
          end else begin
            do_free = 1'b1;
            view_rd = '0;
          end
          view_write = 1'b0;
          if (sb_valid_q && (sb_key_q == pop_data_i.req.key)) begin
            sb_valid_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sb_valid_q  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        sb_valid_q <= sb_valid_d;
        if (do_alloc) begin
          valid_q[free_idx] <= 1'b1;
        end
        if (do_free) begin
          valid_q[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // entry payload, result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.status          <= status;
      out_q.readers         <= view_rd;
      out_q.write_held      <= view_write;
      out_q.superblock_held <= sb_valid_d;
      if (sb_set) begin
        sb_key_q <= pop_data_i.req.key;
      end
      if (do_alloc) begin
        key_q[free_idx]   <= pop_data_i.req.key;
        write_q[free_idx] <= alloc_write;
        rd_q[free_idx]    <= alloc_write ? '0 : RD_W'(1);
      end
      if (do_inc || do_dec) begin
        rd_q[hit_idx] <= view_rd;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== tb/reader_writer_lock_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_writer_lock_table_top_tb
// Self-checking bench for the lock table. A short directed run walks through
// lock conflicts, the superblock rules, range changes and an empty range. A
// burst drives one key to reader overflow. Random phases then use a small key
// pool around the configured range so the table fills and locks collide.
// Each accepted request goes through an in-bench copy of the table, and every
// result is checked in order against the predicted result.
// ----------------------------------------------------------------------------
module reader_writer_lock_table_top_tb;
  import rwlt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // predicts the lock table and checks results in order
  class lock_checker;
    logic [KEY_W-1:0] low_key;
    logic [KEY_W-1:0] high_key;
    bit               used       [TABLE_ENTRIES];
    logic [KEY_W-1:0] owner_key  [TABLE_ENTRIES];
    bit               excl       [TABLE_ENTRIES];
    int unsigned      shared_cnt [TABLE_ENTRIES];
    bit               sb_held;
    logic [KEY_W-1:0] sb_key;
    rsp_t             pending_results[$];
    int unsigned      mismatches;

    function new();
      low_key    = '0;
      high_key   = '1;
      sb_held    = 1'b0;
      sb_key     = '0;
      mismatches = 0;
      foreach (used[i]) begin
        used[i]       = 1'b0;
        owner_key[i]  = '0;
        excl[i]       = 1'b0;
        shared_cnt[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
      if (idx == CFG_LOW_KEY) begin
        low_key = data;
      end else if (idx == CFG_HIGH_KEY) begin
        high_key = data;
      end
    endfunction

    function bit key_ok(logic [KEY_W-1:0] k);
      return (k >= low_key) && (k <= high_key);
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (used[i] && owner_key[i] == k) return i;
      end
      return -1;
    endfunction

    // lowest-numbered free slot
    function int first_free();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!used[i]) return i;
      end
      return -1;
    endfunction

    function status_e take_exclusive(logic [KEY_W-1:0] k);
      int e;
      if (!key_ok(k)) return ST_INVALID;
      if (lookup(k) >= 0) return ST_ALREADY;
      e = first_free();
      if (e < 0) return ST_FULL;
      used[e]       = 1'b1;
      owner_key[e]  = k;
      excl[e]       = 1'b1;
      shared_cnt[e] = 0;
      return ST_OK;
    endfunction

    function status_e take_shared(logic [KEY_W-1:0] k);
      int e;
      if (!key_ok(k)) return ST_INVALID;
      e = lookup(k);
      if (e >= 0) begin
        if (excl[e]) return ST_WRITE_LOCKED;
        if (shared_cnt[e] >= int'(MAX_READERS)) return ST_OVERFLOW;
        shared_cnt[e]++;
        return ST_OK;
      end
      e = first_free();
      if (e < 0) return ST_FULL;
      used[e]       = 1'b1;
      owner_key[e]  = k;
      excl[e]       = 1'b0;
      shared_cnt[e] = 1;
      return ST_OK;
    endfunction

    function status_e release_key(logic [KEY_W-1:0] k);
      int e;
      if (!key_ok(k)) return ST_INVALID;
      e = lookup(k);
      if (e < 0) return ST_NOT_LOCKED;
      if (!excl[e] && shared_cnt[e] > 1) begin
        shared_cnt[e]--;
      end else begin
        used[e]       = 1'b0;
        excl[e]       = 1'b0;
        shared_cnt[e] = 0;
      end
      if (sb_held && sb_key == k) sb_held = 1'b0;
      return ST_OK;
    endfunction

    // apply an accepted request and queue its result
    function void note_request(req_t r);
      status_e st;
      int      e;
      rsp_t    res;
      case (r.op)
        OP_READ:  st = take_shared(r.key);
        OP_WRITE: st = take_exclusive(r.key);
        OP_SB: begin
          if (sb_held) begin
            st = ST_SB_HELD;
          end else begin
            st = take_exclusive(r.key);
            if (st == ST_OK) begin
              sb_held = 1'b1;
              sb_key  = r.key;
            end
          end
        end
        default:  st = release_key(r.key);
      endcase
      e = lookup(r.key);
      res.status          = st;
      res.readers         = (e >= 0 && !excl[e]) ? RD_W'(shared_cnt[e]) : '0;
      res.write_held      = (e >= 0) ? excl[e] : 1'b0;
      res.superblock_held = sb_held;
      pending_results.push_back(res);
    endfunction

    // compare a result with the oldest prediction
    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d readers %0d write %0b sb %0b",
                   got.status, got.readers, got.write_held, got.superblock_held);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.readers !== want.readers ||
          got.write_held !== want.write_held ||
          got.superblock_held !== want.superblock_held) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected status %0d readers %0d write %0b sb %0b,",
                   want.status, want.readers, want.write_held, want.superblock_held);
          $display("  got status %0d readers %0d write %0b sb %0b",
                   got.status, got.readers, got.write_held, got.superblock_held);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  req_t                 in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  rsp_t                 out_rsp_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [KEY_W-1:0]     cfg_data_i  = '0;

  lock_checker locks = new();
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycles       = 0;

  reader_writer_lock_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("reader_writer_lock_table_top_tb NOT OK");
      $finish;
    end
  end

  // random result stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watch all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) locks.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) locks.note_request(in_req_i);
      if (out_valid_o && out_ready_i) locks.check_result(out_rsp_o);
    end
  end

  function automatic req_t make_req(op_e op, logic [KEY_W-1:0] key);
    req_t r;
    r.op  = op;
    r.key = key;
    return r;
  endfunction

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_READ;
    if (r < 55) return OP_WRITE;
    if (r < 63) return OP_SB;
    return OP_UNLOCK;
  endfunction

  // mostly a small pool straddling the low end of the range
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      r;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] span;
    r  = $urandom_range(99);
    lo = locks.low_key;
    hi = locks.high_key;
    if (r < 80) begin
      span = (hi >= lo) ? (hi - lo) : '0;
      if (span > 18) span = 18;
      return lo - 64'd2 + 64'($urandom_range(0, int'(span) + 4));
    end
    if (r < 90) return {$urandom, $urandom};
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return lo;
      default: return hi;
    endcase
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 56; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 56; end
      default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
    endcase
  endtask

  // present one request, idling first at random
  task automatic send_request(req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (locks.pending() != 0) @(posedge clk_i);
  endtask

  // write both range registers while the block is idle
  task automatic set_range(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LOW_KEY;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_HIGH_KEY;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // open the range and unlock everything still held
  task automatic release_all();
    req_t plan[$];
    set_range('0, '1);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (locks.used[i]) begin
        for (int n = 0; n < (locks.excl[i] ? 1 : int'(locks.shared_cnt[i])); n++) begin
          plan.push_back(make_req(OP_UNLOCK, locks.owner_key[i]));
        end
      end
    end
    foreach (plan[i]) send_request(plan[i]);
  endtask

  task automatic random_phase(int n, int mode, logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi);
    set_range(lo, hi);
    set_idling(mode);
    for (int i = 0; i < n; i++) begin
      // hold off once so the pipeline runs dry mid phase
      if (i == n / 2) drain();
      send_request(make_req(pick_op(), pick_key()));
    end
  endtask

  initial begin
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] burst_key;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: conflicts and superblock rules on the full range
    set_idling(0);
    send_request(make_req(OP_READ,   64'd0));
    send_request(make_req(OP_READ,   64'd0));
    send_request(make_req(OP_WRITE,  64'd0));
    send_request(make_req(OP_WRITE,  '1));
    send_request(make_req(OP_READ,   '1));
    send_request(make_req(OP_UNLOCK, '1));
    send_request(make_req(OP_SB,     64'd5));
    send_request(make_req(OP_SB,     64'd6));
    send_request(make_req(OP_READ,   64'd5));
    send_request(make_req(OP_UNLOCK, 64'd5));
    send_request(make_req(OP_UNLOCK, 64'd5));
    // failed superblock lock on a read locked key reports already locked
    send_request(make_req(OP_SB,     64'd0));
    send_request(make_req(OP_UNLOCK, 64'd0));
    send_request(make_req(OP_UNLOCK, 64'd0));

    // directed: narrow range and its edges
    set_range(64'd10, 64'd20);
    send_request(make_req(OP_READ,   64'd9));
    send_request(make_req(OP_READ,   64'd21));
    send_request(make_req(OP_READ,   64'd10));
    send_request(make_req(OP_WRITE,  64'd20));
    send_request(make_req(OP_SB,     64'd9));
    send_request(make_req(OP_SB,     64'd15));
    // superblock held wins over an out of range key
    send_request(make_req(OP_SB,     64'd21));

    // directed: empty range with locks still held
    set_range(64'd30, 64'd29);
    send_request(make_req(OP_UNLOCK, 64'd15));
    send_request(make_req(OP_READ,   64'd30));
    release_all();

    // read count up to saturation and one past it
    set_idling(2);
    burst_key = {$urandom, $urandom};
    for (int i = 0; i <= int'(MAX_READERS); i++) begin
      send_request(make_req(OP_READ, burst_key));
    end
    release_all();

    // random phases over several ranges and idling patterns
    random_phase(60, 0, '0, '1);
    a = {$urandom, $urandom} & ~64'hff;
    random_phase(60, 1, a, a + 64'd15);
    random_phase(50, 2, '1, '1);
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    random_phase(40, 3, a, b);
    random_phase(50, 0, '0, '0);
    a = {$urandom, $urandom} & ~64'hff;
    random_phase(60, 1, a, a + 64'd40);
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if (a > b) random_phase(60, 2, b, a);
    else random_phase(60, 2, a, b);
    random_phase(60, 3, '0, '1);

    // let any stray result show up
    drain();
    repeat (16) @(posedge clk_i);
    if (locks.mismatches == 0 && locks.pending() == 0) begin
      $display("reader_writer_lock_table_top_tb OK");
    end else begin
      $display("reader_writer_lock_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule
